@@ sv/qau_pkg.sv @@
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, widths, mode codes and fixed-point helpers for the quaternion
// arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

  localparam int WORD_BITS = 16;
  localparam int FRAC_BITS = 12;

  // rounded product keeps the integer bits and FRAC_BITS fraction bits, plus one
  localparam int PROD_W    = 2 * WORD_BITS - FRAC_BITS + 1;
  localparam int BASE_W    = (PROD_W > WORD_BITS + 1) ? PROD_W : WORD_BITS + 1;
  localparam int SUM_W     = BASE_W + 3;
  localparam int NUM_PROD  = 16;
  localparam int NUM_RES   = 9;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [PROD_W-1:0]    prod_t;
  typedef logic signed [SUM_W-1:0]     sum_t;

  localparam logic signed [2*WORD_BITS:0] RND_HALF =
    (2*WORD_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam sum_t FIX_ONE  = sum_t'(1) << FRAC_BITS;
  localparam sum_t WORD_MAX = (sum_t'(1) << (WORD_BITS - 1)) - sum_t'(1);
  localparam sum_t WORD_MIN = -(sum_t'(1) << (WORD_BITS - 1));

  typedef enum logic [2:0] {
    MODE_MUL  = 3'd0,
    MODE_ADD  = 3'd1,
    MODE_SUB  = 3'd2,
    MODE_SCL  = 3'd3,
    MODE_CONJ = 3'd4,
    MODE_ROT  = 3'd5
  } qau_mode_e;

  typedef struct packed {
    logic [2:0] mode;
    word_t      a_w;
    word_t      a_x;
    word_t      a_y;
    word_t      a_z;
    word_t      b_w;
    word_t      b_x;
    word_t      b_y;
    word_t      b_z;
    word_t      scale;
  } qau_req_t;

  typedef struct packed {
    word_t r0;
    word_t r1;
    word_t r2;
    word_t r3;
    word_t r4;
    word_t r5;
    word_t r6;
    word_t r7;
    word_t r8;
    logic  saturated;
  } qau_rsp_t;

  // request plus its rounded products, held between the two logic stages
  typedef struct packed {
    qau_req_t                  req;
    prod_t [NUM_PROD-1:0]      prod;
  } qau_stage_t;

  typedef struct packed {
    word_t val;
    logic  clip;
  } qau_sat_t;

  // product rounded to FRAC_BITS fraction bits, half toward plus infinity
  function automatic prod_t rmul(word_t a, word_t b);
    logic signed [2*WORD_BITS-1:0] full;
    logic signed [2*WORD_BITS:0]   biased;
    full   = a * b;
    biased = {full[2*WORD_BITS-1], full} + RND_HALF;
    return biased[2*WORD_BITS:FRAC_BITS];
  endfunction

  function automatic sum_t ext_p(prod_t p);
    return sum_t'(p);
  endfunction

  function automatic sum_t ext_w(word_t w);
    return sum_t'(w);
  endfunction

  function automatic qau_sat_t sat(sum_t v);
    qau_sat_t s;
    s.clip = 1'b0;
    s.val  = v[WORD_BITS-1:0];
    if (v > WORD_MAX) begin
      s.val  = WORD_MAX[WORD_BITS-1:0];
      s.clip = 1'b1;
    end else if (v < WORD_MIN) begin
      s.val  = WORD_MIN[WORD_BITS-1:0];
      s.clip = 1'b1;
    end
    return s;
  endfunction

endpackage

@@ sv/quaternion_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Hamilton product, add, subtract, scale, conjugate and rotation matrix of
// signed fixed-point quaternions, with rounding and saturation.
// ----------------------------------------------------------------------------
//
//   channel  handshake                 payload
//   -------  ------------------------  ------------------------
//   input    in_valid_i / in_ready_o   in_req_i  (qau_req_t)
//   output   out_valid_o / out_ready_i out_rsp_o (qau_rsp_t)
//
// one request per cycle sustained while out_ready_i is high; a request passes
// the request, product and result registers before out_valid_o rises
// three register stages: request register, product register, result register
// the sixteen multiplier lanes set the first stage, the adders and saturation
// the second
// rst_ni clears only the stage valid bits; payload registers are not reset
// a stall on the output fills the empty stages first, then drops in_ready_o
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qau_pkg::qau_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qau_pkg::qau_rsp_t out_rsp_o
);

  // stage valid bits
  logic v1_q, v2_q, v3_q;
  // stage advance enables
  logic en1, en2, en3;

  qau_pkg::qau_req_t   req_q;
  qau_pkg::qau_stage_t stage_d, stage_q;
  qau_pkg::qau_rsp_t   rsp_d, rsp_q;

  // a stage may load when it is empty or its content moves on
  assign en3 = ~v3_q | out_ready_i;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;

  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign out_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // request register
  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  // multiplier lanes
  qau_mult u_mult (
    .req_i  (req_q),
    .prod_o (stage_d.prod)
  );

  assign stage_d.req = req_q;

  // product register
  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      stage_q <= stage_d;
    end
  end

  // sums and saturation
  qau_combine u_combine (
    .st_i  (stage_q),
    .rsp_o (rsp_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      rsp_q <= rsp_d;
    end
  end

endmodule

@@ sv/qau_mult.sv @@
// ----------------------------------------------------------------------------
// qau_mult
// Operand selection and sixteen rounded multiplier lanes, shared by the
// Hamilton product, scaling and rotation matrix modes.
// ----------------------------------------------------------------------------
module qau_mult (
  input  qau_pkg::qau_req_t                       req_i,
  output qau_pkg::prod_t [qau_pkg::NUM_PROD-1:0]  prod_o
);

  qau_pkg::word_t opa [qau_pkg::NUM_PROD];
  qau_pkg::word_t opb [qau_pkg::NUM_PROD];

  always_comb begin
    for (int i = 0; i < qau_pkg::NUM_PROD; i++) begin
      opa[i] = '0;
      opb[i] = '0;
    end
    // lanes 0..3 always take w, x, y, z of a
    opa[0] = req_i.a_w;
    opa[1] = req_i.a_x;
    opa[2] = req_i.a_y;
    opa[3] = req_i.a_z;
    unique case (qau_pkg::qau_mode_e'(req_i.mode))
      qau_pkg::MODE_MUL: begin
        for (int i = 4; i < qau_pkg::NUM_PROD; i++) begin
          opa[i] = opa[i % 4];
        end
        opb[0]  = req_i.b_w; opb[1]  = req_i.b_x;
        opb[2]  = req_i.b_y; opb[3]  = req_i.b_z;
        opb[4]  = req_i.b_x; opb[5]  = req_i.b_w;
        opb[6]  = req_i.b_z; opb[7]  = req_i.b_y;
        opb[8]  = req_i.b_y; opb[9]  = req_i.b_z;
        opb[10] = req_i.b_w; opb[11] = req_i.b_x;
        opb[12] = req_i.b_z; opb[13] = req_i.b_y;
        opb[14] = req_i.b_x; opb[15] = req_i.b_w;
      end
      qau_pkg::MODE_SCL: begin
        for (int i = 0; i < 4; i++) begin
          opb[i] = req_i.scale;
        end
      end
      qau_pkg::MODE_ROT: begin
        // ww xx yy zz xy xz yz wx wy wz
        opb[0] = req_i.a_w; opb[1] = req_i.a_x;
        opb[2] = req_i.a_y; opb[3] = req_i.a_z;
        opa[4] = req_i.a_x; opb[4] = req_i.a_y;
        opa[5] = req_i.a_x; opb[5] = req_i.a_z;
        opa[6] = req_i.a_y; opb[6] = req_i.a_z;
        opa[7] = req_i.a_w; opb[7] = req_i.a_x;
        opa[8] = req_i.a_w; opb[8] = req_i.a_y;
        opa[9] = req_i.a_w; opb[9] = req_i.a_z;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < qau_pkg::NUM_PROD; g++) begin : g_lane
    assign prod_o[g] = qau_pkg::rmul(opa[g], opb[g]);
  end

endmodule

@@ sv/qau_combine.sv @@
// ----------------------------------------------------------------------------
// qau_combine
// Adds up the rounded products (or the raw components) per mode and
// saturates every element to the word range.
// ----------------------------------------------------------------------------
module qau_combine (
  input  qau_pkg::qau_stage_t st_i,
  output qau_pkg::qau_rsp_t   rsp_o
);

  qau_pkg::sum_t r [qau_pkg::NUM_RES];
  qau_pkg::sum_t p [qau_pkg::NUM_PROD];
  qau_pkg::word_t res [qau_pkg::NUM_RES];
  logic          clip_any;

  always_comb begin
    for (int i = 0; i < qau_pkg::NUM_PROD; i++) begin
      p[i] = qau_pkg::ext_p(st_i.prod[i]);
    end
    for (int i = 0; i < qau_pkg::NUM_RES; i++) begin
      r[i] = '0;
    end
    unique case (qau_pkg::qau_mode_e'(st_i.req.mode))
      qau_pkg::MODE_MUL: begin
        r[0] = p[0]  - p[1]  - p[2]  - p[3];
        r[1] = p[4]  + p[5]  + p[6]  - p[7];
        r[2] = p[8]  - p[9]  + p[10] + p[11];
        r[3] = p[12] + p[13] - p[14] + p[15];
      end
      qau_pkg::MODE_ADD: begin
        r[0] = qau_pkg::ext_w(st_i.req.a_w) + qau_pkg::ext_w(st_i.req.b_w);
        r[1] = qau_pkg::ext_w(st_i.req.a_x) + qau_pkg::ext_w(st_i.req.b_x);
        r[2] = qau_pkg::ext_w(st_i.req.a_y) + qau_pkg::ext_w(st_i.req.b_y);
        r[3] = qau_pkg::ext_w(st_i.req.a_z) + qau_pkg::ext_w(st_i.req.b_z);
      end
      qau_pkg::MODE_SUB: begin
        r[0] = qau_pkg::ext_w(st_i.req.a_w) - qau_pkg::ext_w(st_i.req.b_w);
        r[1] = qau_pkg::ext_w(st_i.req.a_x) - qau_pkg::ext_w(st_i.req.b_x);
        r[2] = qau_pkg::ext_w(st_i.req.a_y) - qau_pkg::ext_w(st_i.req.b_y);
        r[3] = qau_pkg::ext_w(st_i.req.a_z) - qau_pkg::ext_w(st_i.req.b_z);
      end
      qau_pkg::MODE_SCL: begin
        for (int i = 0; i < 4; i++) begin
          r[i] = p[i];
        end
      end
      qau_pkg::MODE_CONJ: begin
        r[0] = qau_pkg::ext_w(st_i.req.a_w);
        r[1] = -qau_pkg::ext_w(st_i.req.a_x);
        r[2] = -qau_pkg::ext_w(st_i.req.a_y);
        r[3] = -qau_pkg::ext_w(st_i.req.a_z);
      end
      qau_pkg::MODE_ROT: begin
        // p: 0 ww, 1 xx, 2 yy, 3 zz, 4 xy, 5 xz, 6 yz, 7 wx, 8 wy, 9 wz
        r[0] = ((p[0] + p[1]) <<< 1) - qau_pkg::FIX_ONE;
        r[1] = (p[4] + p[9]) <<< 1;
        r[2] = (p[5] - p[8]) <<< 1;
        r[3] = (p[4] - p[9]) <<< 1;
        r[4] = ((p[0] + p[2]) <<< 1) - qau_pkg::FIX_ONE;
        r[5] = (p[6] + p[7]) <<< 1;
        r[6] = (p[5] + p[8]) <<< 1;
        r[7] = (p[6] - p[7]) <<< 1;
        r[8] = ((p[0] + p[3]) <<< 1) - qau_pkg::FIX_ONE;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    qau_pkg::qau_sat_t s;
    clip_any = 1'b0;
    for (int i = 0; i < qau_pkg::NUM_RES; i++) begin
      s        = qau_pkg::sat(r[i]);
      res[i]   = s.val;
      clip_any = clip_any | s.clip;
    end
  end

  assign rsp_o.r0        = res[0];
  assign rsp_o.r1        = res[1];
  assign rsp_o.r2        = res[2];
  assign rsp_o.r3        = res[3];
  assign rsp_o.r4        = res[4];
  assign rsp_o.r5        = res[5];
  assign rsp_o.r6        = res[6];
  assign rsp_o.r7        = res[7];
  assign rsp_o.r8        = res[8];
  assign rsp_o.saturated = clip_any;

endmodule
